// ===== sv/wavd_pkg.sv =====
// ----------------------------------------------------------------------------
// wavd_pkg
// Types and constants shared by the WAV PCM stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wavd_pkg;

    localparam int unsigned HEADER_BYTES = 44;
    localparam int unsigned POS_W        = 6;
    localparam int unsigned RATE_W       = 32;
    localparam int unsigned CHAN_W       = 16;
    localparam int unsigned WIDTH_W      = 13;
    localparam int unsigned FRAME_W      = CHAN_W + WIDTH_W;
    localparam int unsigned SAMPLE_W     = 64;

    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_W    = 8'h57;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] FMT_PCM = 8'd1;

    localparam logic [POS_W-1:0] POS_CHAN_LO  = 6'd22;
    localparam logic [POS_W-1:0] POS_CHAN_HI  = 6'd23;
    localparam logic [POS_W-1:0] POS_RATE_0   = 6'd24;
    localparam logic [POS_W-1:0] POS_RATE_3   = 6'd27;
    localparam logic [POS_W-1:0] POS_BITS_LO  = 6'd34;
    localparam logic [POS_W-1:0] POS_BITS_HI  = 6'd35;
    localparam logic [POS_W-1:0] POS_SIZE_0   = 6'd40;
    localparam logic [POS_W-1:0] POS_SIZE_3   = 6'd43;

    typedef enum logic [1:0] {
        KIND_HEADER_OK  = 2'd0,
        KIND_SAMPLE     = 2'd1,
        KIND_HEADER_BAD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CHAN_W-1:0]          channel_index;
        logic                       frame_last;
        logic                       stream_last;
        logic [CHAN_W-1:0]          channel_count;
        logic [WIDTH_W-1:0]         sample_bytes;
        logic [RATE_W-1:0]          sample_rate;
    } t_result;

    // Checks the fixed tag and format bytes of the header.
    function automatic logic tag_match(input logic [POS_W-1:0] pos, input logic [7:0] b);
        logic ok;
        begin
            case (pos)
                6'd0:    ok = (b == CH_R);
                6'd1:    ok = (b == CH_I);
                6'd2:    ok = (b == CH_F);
                6'd3:    ok = (b == CH_F);
                6'd8:    ok = (b == CH_W);
                6'd9:    ok = (b == CH_A);
                6'd10:   ok = (b == CH_V);
                6'd11:   ok = (b == CH_E);
                6'd20:   ok = (b == FMT_PCM);
                6'd21:   ok = (b == 8'd0);
                default: ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/wav_pcm_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_decoder
// One byte per beat; the output stage registers each result beat.
// Throughput is one byte per cycle while the output stage has room.
// A two-entry output stage keeps input ready registered while results wait.
// Synchronous reset clears all state; the first byte after reset is header byte 0.
// A beat with the start flag set clears the decoder and restarts header parsing.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_decoder #(
    parameter int unsigned MAX_SAMPLE_BYTES = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte
    input  wire logic         s_axis_tuser,   // file_start
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [143:0]      m_axis_tdata,   // sample_value, channel_index,
                                              // channel_count, sample_bytes,
                                              // sample_rate, zero pad
    output logic              m_axis_tlast,   // frame_last
    output logic [2:0]        m_axis_tuser    // result_kind, stream_last
);
    import wavd_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    wavd_parse #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser),
        .o_valid  (w_res_valid),
        .o_result (w_res)
    );

    wavd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept && w_res_valid),
        .i_data  (w_res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {3'b000, w_out.sample_rate, w_out.sample_bytes,
                           w_out.channel_count, w_out.channel_index,
                           w_out.sample_value};
    assign m_axis_tlast = w_out.frame_last;
    assign m_axis_tuser = {w_out.stream_last, w_out.kind};

endmodule

`default_nettype wire

// ===== sv/wavd_parse.sv =====
// ----------------------------------------------------------------------------
// wavd_parse
// Header parser and sample assembler; one byte per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wavd_parse #(
    parameter int unsigned MAX_SAMPLE_BYTES = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_start,
    output logic                   o_valid,
    output wavd_pkg::t_result      o_result
);
    import wavd_pkg::*;

    localparam int unsigned ASM_W = 8 * MAX_SAMPLE_BYTES;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_IDLE   = 2'd2
    } t_phase;

    t_phase             r_phase,  n_phase,  c_phase;
    logic [POS_W-1:0]   r_pos,    n_pos,    c_pos;
    logic               r_hvalid, n_hvalid, c_hvalid;
    logic [CHAN_W-1:0]  r_chan,   n_chan,   c_chan;
    logic [WIDTH_W-1:0] r_width,  n_width,  c_width;
    logic [RATE_W-1:0]  r_rate,   n_rate,   c_rate;
    logic [31:0]        r_left,   n_left,   c_left;
    logic [ASM_W-1:0]   r_asm,    n_asm,    c_asm;
    logic [2:0]         r_bis,    n_bis,    c_bis;
    logic [CHAN_W-1:0]  r_cc,     n_cc,     c_cc;
    logic [FRAME_W-1:0] r_frame;

    logic [ASM_W-1:0]   w_asm;
    logic [63:0]        w_full;
    logic [63:0]        w_value;
    logic [31:0]        w_left_dec;
    logic [31:0]        w_size;
    logic               w_ok;
    logic               w_flast;
    logic               w_slast;
    logic [3:0]         w_bis_inc;

    function automatic logic f_width_ok(input logic [WIDTH_W-1:0] w);
        return ((w == 13'd1) || (w == 13'd2) || (w == 13'd3) || (w == 13'd4)
                || (w == 13'd8)) && (w <= WIDTH_W'(MAX_SAMPLE_BYTES));
    endfunction

    always_comb begin
        if (i_start) begin
            c_phase  = PH_HEADER;
            c_pos    = '0;
            c_hvalid = 1'b1;
            c_chan   = '0;
            c_width  = '0;
            c_rate   = '0;
            c_left   = '0;
            c_asm    = '0;
            c_bis    = '0;
            c_cc     = '0;
        end else begin
            c_phase  = r_phase;
            c_pos    = r_pos;
            c_hvalid = r_hvalid;
            c_chan   = r_chan;
            c_width  = r_width;
            c_rate   = r_rate;
            c_left   = r_left;
            c_asm    = r_asm;
            c_bis    = r_bis;
            c_cc     = r_cc;
        end

        n_phase  = c_phase;
        n_pos    = c_pos;
        n_hvalid = c_hvalid;
        n_chan   = c_chan;
        n_width  = c_width;
        n_rate   = c_rate;
        n_left   = c_left;
        n_asm    = c_asm;
        n_bis    = c_bis;
        n_cc     = c_cc;

        w_asm      = c_asm | (ASM_W'(i_byte) << {c_bis, 3'b000});
        w_full     = 64'(w_asm);
        w_left_dec = c_left - 32'd1;
        w_size     = {i_byte, c_left[23:0]};
        w_ok       = c_hvalid && (c_chan != '0) && f_width_ok(c_width);
        w_flast    = ({1'b0, c_cc} + 17'd1) >= {1'b0, c_chan};
        w_slast    = w_flast && (w_left_dec < 32'(r_frame));
        w_bis_inc  = {1'b0, c_bis} + 4'd1;

        case (c_width[3:0])
            4'd1:    w_value = {{57{~w_full[7]}}, w_full[6:0]};
            4'd2:    w_value = {{48{w_full[15]}}, w_full[15:0]};
            4'd3:    w_value = {{40{w_full[23]}}, w_full[23:0]};
            4'd4:    w_value = {{32{w_full[31]}}, w_full[31:0]};
            default: w_value = w_full;
        endcase

        o_valid  = 1'b0;
        o_result = '0;

        unique case (c_phase)
            PH_HEADER: begin
                if (!tag_match(c_pos, i_byte)) begin
                    n_hvalid = 1'b0;
                end
                if (c_pos == POS_CHAN_LO) begin
                    n_chan[7:0] = i_byte;
                end
                if (c_pos == POS_CHAN_HI) begin
                    n_chan[15:8] = i_byte;
                end
                if ((c_pos >= POS_RATE_0) && (c_pos <= POS_RATE_3)) begin
                    n_rate[{c_pos[1:0], 3'b000} +: 8] = i_byte;
                end
                if (c_pos == POS_BITS_LO) begin
                    n_width[4:0] = i_byte[7:3];
                end
                if (c_pos == POS_BITS_HI) begin
                    n_width[12:5] = i_byte;
                end
                if ((c_pos >= POS_SIZE_0) && (c_pos <= POS_SIZE_3)) begin
                    n_left[{c_pos[1:0], 3'b000} +: 8] = i_byte;
                end
                if (c_pos == POS_SIZE_3) begin
                    n_pos                  = '0;
                    o_valid                = 1'b1;
                    o_result.kind          = w_ok ? KIND_HEADER_OK : KIND_HEADER_BAD;
                    o_result.channel_count = c_chan;
                    o_result.sample_bytes  = c_width;
                    o_result.sample_rate   = c_rate;
                    if (w_ok) begin
                        n_phase = (w_size >= 32'(r_frame)) ? PH_DATA : PH_IDLE;
                    end else begin
                        n_chan  = '0;
                        n_width = '0;
                        n_rate  = '0;
                        n_left  = '0;
                        n_phase = PH_IDLE;
                    end
                    n_asm = '0;
                    n_bis = '0;
                    n_cc  = '0;
                end else begin
                    n_pos = c_pos + 6'd1;
                end
            end
            PH_DATA: begin
                n_left = w_left_dec;
                if ({9'd0, w_bis_inc} < c_width) begin
                    n_asm = w_asm;
                    n_bis = w_bis_inc[2:0];
                end else begin
                    o_valid                = 1'b1;
                    o_result.kind          = KIND_SAMPLE;
                    o_result.sample_value  = w_value;
                    o_result.channel_index = c_cc;
                    o_result.frame_last    = w_flast;
                    o_result.stream_last   = w_slast;
                    n_cc  = w_flast ? '0 : (c_cc + 16'd1);
                    n_asm = '0;
                    n_bis = '0;
                    if (w_slast) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_hvalid <= 1'b1;
            r_chan   <= '0;
            r_width  <= '0;
            r_rate   <= '0;
            r_left   <= '0;
            r_asm    <= '0;
            r_bis    <= '0;
            r_cc     <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_hvalid <= n_hvalid;
            r_chan   <= n_chan;
            r_width  <= n_width;
            r_rate   <= n_rate;
            r_left   <= n_left;
            r_asm    <= n_asm;
            r_bis    <= n_bis;
            r_cc     <= n_cc;
        end
    end

    // The frame size settles well before the last header byte needs it.
    always_ff @(posedge i_clk) begin
        r_frame <= FRAME_W'(r_chan) * FRAME_W'(r_width);
    end

endmodule

`default_nettype wire

// ===== sv/wavd_skid.sv =====
// ----------------------------------------------------------------------------
// wavd_skid
// Output register with a skid stage, so the input side sees a registered ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wavd_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire wavd_pkg::t_result i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output wavd_pkg::t_result      o_data
);
    import wavd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_move;

    assign w_move  = !r_out_valid || i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!w_move && i_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the WAV PCM stream decoder. WAV files are fed in
// one byte per beat: first a directed list of files covering every sample
// width, the value extremes, each header rejection, frame truncation and
// restarts part-way through a file, then random files with mostly valid
// headers and some corrupted, aborted or noisy input. A decoder model or the
// file list (directed headers) predicts each beat, compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import wavd_pkg::*;

    localparam int unsigned    MAX_BYTES    = 8;
    localparam int unsigned    TOTAL_BYTES  = 1450;
    localparam int unsigned    CYCLE_LIMIT  = 200000;
    localparam int unsigned    HOLD_CYCLES  = 400;
    localparam logic [31:0]    RIFF_TAG     = "RIFF";
    localparam logic [31:0]    WAVE_TAG     = "WAVE";
    localparam logic [31:0]    FMT_TAG      = "fmt ";
    localparam logic [31:0]    DATA_TAG     = "data";
    localparam logic [31:0]    EXT_BYTES    = 32'h7F80_FF00;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic        start;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] size;
        logic [5:0]  hdr_len;
        logic        bad_en;
        logic [5:0]  bad_pos;
        logic [7:0]  bad_val;
        logic [15:0] n_data;
        logic        ext_pattern;
        logic        typed;
        t_kind       want_kind;
    } t_wav_file;

    localparam int unsigned N_DIR = 23;
    localparam t_wav_file DIR_FILES [N_DIR] = '{
        '{0, 1,      8,  8000,         8,   44, 0, 0,  0,     8,  1, 1, KIND_HEADER_OK},
        '{1, 2,      16, 44100,        12,  44, 0, 0,  0,     14, 1, 1, KIND_HEADER_OK},
        '{1, 1,      24, 32'hFFFFFFFF, 10,  44, 0, 0,  0,     10, 1, 1, KIND_HEADER_OK},
        '{1, 3,      32, 0,            24,  44, 0, 0,  0,     24, 1, 1, KIND_HEADER_OK},
        '{1, 2,      64, 96000,        32,  44, 0, 0,  0,     32, 1, 1, KIND_HEADER_OK},
        '{1, 16'hFFFF, 8, 22050,       100, 44, 0, 0,  0,     4,  0, 1, KIND_HEADER_OK},
        '{1, 2,      16, 48000,        5,   44, 0, 0,  0,     5,  0, 1, KIND_HEADER_OK},
        '{1, 1,      12, 11025,        6,   44, 0, 0,  0,     6,  0, 1, KIND_HEADER_OK},
        '{1, 1,      16, 8000,         4,   44, 1, 0,  8'h72, 4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      16, 8000,         4,   44, 1, 3,  8'h58, 4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      16, 8000,         4,   44, 1, 8,  8'h77, 4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      16, 8000,         4,   44, 1, 11, 8'h00, 4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      16, 8000,         4,   44, 1, 20, 8'h03, 4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      16, 8000,         4,   44, 1, 21, 8'h01, 4,  0, 1, KIND_HEADER_BAD},
        '{1, 0,      16, 8000,         4,   44, 0, 0,  0,     4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      40, 8000,         10,  44, 0, 0,  0,     10, 0, 1, KIND_HEADER_BAD},
        '{1, 1,      0,  8000,         4,   44, 0, 0,  0,     4,  0, 1, KIND_HEADER_BAD},
        '{1, 1, 16'hFFFF, 8000,        4,   44, 0, 0,  0,     4,  0, 1, KIND_HEADER_BAD},
        '{1, 1,      72, 8000,         18,  44, 0, 0,  0,     18, 0, 1, KIND_HEADER_BAD},
        '{1, 1,      48, 8000,         12,  44, 0, 0,  0,     12, 0, 1, KIND_HEADER_BAD},
        '{1, 2,      16, 44100,        40,  20, 0, 0,  0,     0,  0, 0, KIND_HEADER_OK},
        '{1, 1,      16, 8000,         20,  44, 0, 0,  0,     7,  1, 1, KIND_HEADER_OK},
        '{1, 4,      8,  16000,        16,  44, 0, 0,  0,     16, 0, 1, KIND_HEADER_OK}
    };

    logic           i_clk;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata  = '0;
    logic           s_axis_tuser  = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [143:0]   m_axis_tdata;
    logic           m_axis_tlast;
    logic [2:0]     m_axis_tuser;

    t_phase         phase;
    int             hdr_pos;
    logic           hdr_good;
    logic [15:0]    chans;
    logic [12:0]    wbytes;
    logic [31:0]    rate;
    logic [31:0]    left;
    logic [63:0]    acc;
    logic [2:0]     bidx;
    logic [15:0]    chan_ctr;

    t_result        pending_results [$];
    int unsigned    mismatches  = 0;
    int unsigned    busy_bytes  = 0;
    int unsigned    cycles      = 0;
    logic           calm        = 1'b0;
    logic           hold_off    = 1'b0;
    bit             hold_armed  = 1'b0;
    bit             hold_go     = 1'b0;

    wav_pcm_stream_decoder #(
        .MAX_SAMPLE_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_decoder();
        phase    = PH_HEADER;
        hdr_pos  = 0;
        hdr_good = 1'b1;
        chans    = '0;
        wbytes   = '0;
        rate     = '0;
        left     = '0;
        acc      = '0;
        bidx     = '0;
        chan_ctr = '0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output t_result r);
        logic [63:0] v;
        logic [63:0] frame;
        logic        flast;
        logic        checked;
        logic [7:0]  want_b;
        int          pos;
        r = '0;
        if (st) begin
            clear_decoder();
        end
        if (phase == PH_HEADER) begin
            pos     = hdr_pos;
            checked = 1'b1;
            want_b  = 8'd0;
            if (pos < 4) begin
                want_b = RIFF_TAG[8*(3-pos) +: 8];
            end else if (pos >= 8 && pos < 12) begin
                want_b = WAVE_TAG[8*(11-pos) +: 8];
            end else if (pos == 20) begin
                want_b = FMT_PCM;
            end else if (pos != 21) begin
                checked = 1'b0;
            end
            if (checked && b != want_b) begin
                hdr_good = 1'b0;
            end
            case (pos)
                22: chans[7:0] = b;
                23: chans[15:8] = b;
                24, 25, 26, 27: rate[8*(pos-24) +: 8] = b;
                34: wbytes[4:0] = b[7:3];
                35: wbytes[12:5] = b;
                40, 41, 42, 43: left[8*(pos-40) +: 8] = b;
                default: ;
            endcase
            if (pos < HEADER_BYTES - 1) begin
                hdr_pos = pos + 1;
                return 1'b0;
            end
            hdr_pos = 0;
            r.kind = (hdr_good && chans != 0 && wbytes inside {1, 2, 3, 4, 8}
                      && wbytes <= MAX_BYTES) ? KIND_HEADER_OK : KIND_HEADER_BAD;
            r.channel_count = chans;
            r.sample_bytes  = wbytes;
            r.sample_rate   = rate;
            if (r.kind == KIND_HEADER_OK) begin
                frame = 64'(chans) * 64'(wbytes);
                left  = 32'((64'(left) / frame) * frame);
                phase = (left != 0) ? PH_DATA : PH_IDLE;
            end else begin
                chans  = '0;
                wbytes = '0;
                rate   = '0;
                left   = '0;
                phase  = PH_IDLE;
            end
            acc      = '0;
            bidx     = '0;
            chan_ctr = '0;
            return 1'b1;
        end
        if (phase == PH_DATA) begin
            acc  = acc | (64'(b) << (8 * bidx));
            left = left - 32'd1;
            if (bidx + 1 < wbytes) begin
                bidx = bidx + 3'd1;
                return 1'b0;
            end
            v = acc;
            if (wbytes == 1) begin
                v = {56'd0, acc[7:0]} - 64'd128;
            end else if (wbytes < 8 && acc[8*wbytes-1]) begin
                v = acc | ~((64'd1 << (8 * wbytes)) - 64'd1);
            end
            flast             = (32'(chan_ctr) + 32'd1 >= 32'(chans));
            r.kind            = KIND_SAMPLE;
            r.sample_value    = v;
            r.channel_index   = chan_ctr;
            r.frame_last      = flast;
            r.stream_last     = (left == 0);
            chan_ctr          = flast ? 16'd0 : chan_ctr + 16'd1;
            acc               = '0;
            bidx              = '0;
            if (left == 0) begin
                phase = PH_IDLE;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic st, input bit typed,
                             input t_result want);
        t_result r;
        bit      produced;
        while (!calm && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        busy_bytes++;
        if (hold_armed && busy_bytes >= 300 && phase == PH_DATA) begin
            hold_go = 1'b1;
        end
        produced = decode_byte(b, st, r);
        if (produced) begin
            pending_results.push_back((typed && r.kind != KIND_SAMPLE) ? want : r);
        end
        @(negedge i_clk);
    endtask

    task automatic send_file(input t_wav_file f);
        logic [7:0]  hdr [HEADER_BYTES];
        logic [31:0] riff_size;
        logic [31:0] byte_rate;
        logic [31:0] fmt_len;
        logic [15:0] fmt_code;
        logic [15:0] blk_align;
        t_result     want;
        int          k;
        riff_size = f.size + 32'd36;
        blk_align = f.chans * (f.bits >> 3);
        byte_rate = f.rate * blk_align;
        fmt_len   = 32'd16;
        fmt_code  = {8'd0, FMT_PCM};
        for (k = 0; k < 4; k++) begin
            hdr[k]      = RIFF_TAG[8*(3-k) +: 8];
            hdr[4 + k]  = riff_size[8*k +: 8];
            hdr[8 + k]  = WAVE_TAG[8*(3-k) +: 8];
            hdr[12 + k] = FMT_TAG[8*(3-k) +: 8];
            hdr[16 + k] = fmt_len[8*k +: 8];
            hdr[24 + k] = f.rate[8*k +: 8];
            hdr[28 + k] = byte_rate[8*k +: 8];
            hdr[36 + k] = DATA_TAG[8*(3-k) +: 8];
            hdr[40 + k] = f.size[8*k +: 8];
        end
        for (k = 0; k < 2; k++) begin
            hdr[20 + k] = fmt_code[8*k +: 8];
            hdr[22 + k] = f.chans[8*k +: 8];
            hdr[32 + k] = blk_align[8*k +: 8];
            hdr[34 + k] = f.bits[8*k +: 8];
        end
        if (f.bad_en) begin
            hdr[f.bad_pos] = f.bad_val;
        end
        want               = '0;
        want.kind          = f.want_kind;
        want.channel_count = f.chans;
        want.sample_bytes  = f.bits[15:3];
        want.sample_rate   = f.rate;
        for (k = 0; k < f.hdr_len; k++) begin
            push_byte(hdr[k], (k == 0) && f.start, f.typed, want);
        end
        for (k = 0; k < f.n_data; k++) begin
            push_byte(f.ext_pattern ? EXT_BYTES[8*(k%4) +: 8] : 8'($urandom_range(255)),
                      1'b0, 1'b0, want);
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.kind          = t_kind'(m_axis_tuser[1:0]);
        got.sample_value  = m_axis_tdata[63:0];
        got.channel_index = m_axis_tdata[79:64];
        got.frame_last    = m_axis_tlast;
        got.stream_last   = m_axis_tuser[2];
        got.channel_count = m_axis_tdata[95:80];
        got.sample_bytes  = m_axis_tdata[108:96];
        got.sample_rate   = m_axis_tdata[140:109];
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result beat with nothing expected: kind %0d value %h",
                         $realtime, got.kind, got.sample_value);
            end
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.sample_value !== want.sample_value
                || got.channel_index !== want.channel_index
                || got.frame_last !== want.frame_last
                || got.stream_last !== want.stream_last
                || got.channel_count !== want.channel_count
                || got.sample_bytes !== want.sample_bytes
                || got.sample_rate !== want.sample_rate) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result mismatch", $realtime);
                $display("  expected kind %0d value %h chan %0d flast %b slast %b",
                         want.kind, want.sample_value, want.channel_index,
                         want.frame_last, want.stream_last);
                $display("           count %0d bytes %0d rate %0d",
                         want.channel_count, want.sample_bytes, want.sample_rate);
                $display("  actual   kind %0d value %h chan %0d flast %b slast %b",
                         got.kind, got.sample_value, got.channel_index,
                         got.frame_last, got.stream_last);
                $display("           count %0d bytes %0d rate %0d",
                         got.channel_count, got.sample_bytes, got.sample_rate);
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result();
        end
    end

    // The receiver holds off for a long stretch while bytes keep arriving.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_wav_file   f;
        int          i;
        int          n;
        int          w;
        int          pick;
        logic [31:0] frame;
        clear_decoder();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        hold_armed = 1'b1;
        for (i = 0; i < N_DIR; i++) begin
            calm <= (busy_bytes >= 700 && busy_bytes < 1000);
            send_file(DIR_FILES[i]);
        end

        while (busy_bytes < TOTAL_BYTES) begin
            calm <= (busy_bytes >= 700 && busy_bytes < 1000);
            if ($urandom_range(99) < 5) begin
                n = $urandom_range(1, 30);
                for (i = 0; i < n; i++) begin
                    push_byte(8'($urandom_range(255)), $urandom_range(9) == 0, 1'b0, '0);
                end
            end else begin
                f       = '0;
                f.start = ($urandom_range(99) >= 3);
                pick    = $urandom_range(99);
                if (pick < 70) begin
                    f.chans = 16'($urandom_range(1, 4));
                end else if (pick < 90) begin
                    f.chans = 16'($urandom_range(5, 16));
                end else begin
                    f.chans = 16'($urandom_range(0, 65535));
                end
                case ($urandom_range(4))
                    0: w = 1;
                    1: w = 2;
                    2: w = 3;
                    3: w = 4;
                    default: w = 8;
                endcase
                if ($urandom_range(99) < 10) begin
                    f.bits = 16'($urandom_range(0, 65535));
                end else begin
                    f.bits = 16'(w * 8 + $urandom_range(0, 7));
                end
                f.rate = $urandom;
                frame  = f.chans * w;
                if ($urandom_range(99) < 8) begin
                    f.size   = $urandom;
                    f.n_data = 16'($urandom_range(0, 150));
                end else begin
                    if (frame <= 64) begin
                        f.size = frame * $urandom_range(0, 6) + $urandom_range(0, frame);
                    end else begin
                        f.size = $urandom_range(0, 200);
                    end
                    f.n_data = 16'(f.size + $urandom_range(0, 3));
                end
                f.hdr_len = 6'(HEADER_BYTES);
                if ($urandom_range(99) < 8) begin
                    f.hdr_len = 6'($urandom_range(1, 43));
                    f.n_data  = '0;
                end
                f.bad_en      = ($urandom_range(99) < 12);
                f.bad_pos     = 6'($urandom_range(0, 43));
                f.bad_val     = 8'($urandom_range(255));
                f.ext_pattern = ($urandom_range(99) < 10);
                f.want_kind   = KIND_HEADER_OK;
                send_file(f);
            end
        end

        s_axis_tvalid <= 1'b0;
        calm          <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
